/* hw/rtl/indexed_list_with_min_sum_macros.svh */
// ----------------------------------------------------------------------------
// indexed list assertion macros
// concurrent property helpers used by ilms_back, the rtl file that checks itself
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_WITH_MIN_SUM_MACROS_SVH
`define INDEXED_LIST_WITH_MIN_SUM_MACROS_SVH

// same-cycle implication, disabled during reset
`define ILMS_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ILMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ilms_pkg.sv */
// ----------------------------------------------------------------------------
// ilms_pkg
// shared widths, request codes, status codes, command kinds and the command format
// ----------------------------------------------------------------------------
package ilms_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = ADDR_W + 1;
  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int ST_W     = 2;
  localparam int RES_W    = 38;
  localparam int KIND_W   = 3;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = Q_PTR_W + 1;

  // request codes
  localparam logic [OP_W-1:0] OP_PRINT  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_MIN    = 3'd3;
  localparam logic [OP_W-1:0] OP_SUM    = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // classified command kinds
  localparam logic [KIND_W-1:0] KIND_IMM    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LIST   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MIN    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SUM    = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value;
    logic [ADDR_W-1:0]       pos;
  } cmd_t;

endpackage

/* hw/rtl/ilms_front.sv */
// ----------------------------------------------------------------------------
// ilms_front
// accepts requests, tracks the list length and classifies each request;
// unused op codes are taken and dropped
module ilms_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ilms_pkg::OP_W-1:0]     in_op,
  input  logic signed [ilms_pkg::VAL_W-1:0] in_item_value,
  input  logic [ilms_pkg::POS_W-1:0]    in_position,
  input  logic                          q_full,
  output logic                          push,
  output ilms_pkg::cmd_t                push_cmd
);
  import ilms_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             accept;
  logic             is_empty;
  logic             is_full;
  logic             pos_bad;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_empty = (cnt_r == '0);
  assign is_full  = (cnt_r >= CNT_W'(CAPACITY));
  assign pos_bad  = (in_position >= {{(POS_W-CNT_W){1'b0}}, cnt_r});

  always_comb begin
    push            = 1'b0;
    cnt_nxt         = cnt_r;
    push_cmd.kind   = KIND_IMM;
    push_cmd.status = ST_OK;
    push_cmd.value  = in_item_value;
    push_cmd.pos    = in_position[ADDR_W-1:0];
    if (accept) begin
      case (in_op)
        OP_PRINT: begin
          push = 1'b1;
          if (is_empty) begin
            push_cmd.status = ST_EMPTY;
          end else begin
            push_cmd.kind = KIND_LIST;
          end
        end
        OP_APPEND: begin
          push = 1'b1;
          if (is_full) begin
            push_cmd.status = ST_FULL;
          end else begin
            push_cmd.kind = KIND_APPEND;
            cnt_nxt       = cnt_r + 1'b1;
          end
        end
        OP_DELETE, OP_MIN: begin
          push = 1'b1;
          if (is_empty) begin
            push_cmd.status = ST_EMPTY;
          end else if (pos_bad) begin
            push_cmd.status = ST_RANGE;
          end else if (in_op == OP_DELETE) begin
            push_cmd.kind = KIND_DELETE;
            cnt_nxt       = cnt_r - 1'b1;
          end else begin
            push_cmd.kind = KIND_MIN;
          end
        end
        OP_SUM: begin
          push = 1'b1;
          if (!is_empty) begin
            push_cmd.kind = KIND_SUM;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/ilms_queue.sv */
// ----------------------------------------------------------------------------
// ilms_queue
// short command queue between the classifier and the list engine
// ----------------------------------------------------------------------------
module ilms_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ilms_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output ilms_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import ilms_pkg::*;

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] fill_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (fill_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/ilms_back.sv */
// ----------------------------------------------------------------------------
// ilms_back
// list engine: entry memory, walk over entries, result register
// ----------------------------------------------------------------------------
`include "indexed_list_with_min_sum_macros.svh"

module ilms_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  ilms_pkg::cmd_t                    q_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ilms_pkg::ST_W-1:0]         out_status,
  output logic signed [ilms_pkg::RES_W-1:0] out_result_value,
  output logic                              out_last
);
  import ilms_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic signed [VAL_W-1:0] mem [CAPACITY];

  logic [1:0]              state_r,   state_nxt;
  logic [KIND_W-1:0]       kind_r,    kind_nxt;
  logic [ST_W-1:0]         status_r,  status_nxt;
  logic [CNT_W-1:0]        count_r,   count_nxt;
  logic [CNT_W-1:0]        start_r,   start_nxt;
  logic [CNT_W-1:0]        end_r,     end_nxt;
  logic [CNT_W-1:0]        iss_r,     iss_nxt;
  logic [CNT_W-1:0]        rd_idx_r,  rd_idx_nxt;
  logic                    rd_valid_r, rd_valid_nxt;
  logic signed [VAL_W-1:0] rd_data_r;
  logic signed [RES_W-1:0] acc_r,     acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]         out_status_r, out_status_nxt;
  logic signed [RES_W-1:0] out_value_r,  out_value_nxt;
  logic                    out_last_r,   out_last_nxt;

  logic                    out_free;
  logic                    consume;
  logic                    advance;
  logic                    rd_en;
  logic                    rd_last;
  logic                    rd_first;
  logic signed [RES_W-1:0] rd_ext;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign consume  = rd_valid_r && ((kind_r != KIND_LIST) || out_free);
  assign advance  = !rd_valid_r || consume;
  assign rd_en    = (state_r == S_WALK) && advance && (iss_r < end_r);
  assign rd_last  = (rd_idx_r == end_r - 1'b1);
  assign rd_first = (rd_idx_r == start_r);
  assign rd_ext   = {{(RES_W-VAL_W){rd_data_r[VAL_W-1]}}, rd_data_r};

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    status_nxt     = status_r;
    count_nxt      = count_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    iss_nxt        = iss_r;
    acc_nxt        = acc_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    wr_en          = 1'b0;
    wr_addr        = count_r[ADDR_W-1:0];
    wr_data        = q_cmd.value;
    rd_idx_nxt     = rd_en ? iss_r : rd_idx_r;
    rd_valid_nxt   = rd_en || (rd_valid_r && !consume);
    if (rd_en) begin
      iss_nxt = iss_r + 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          kind_nxt   = q_cmd.kind;
          status_nxt = ST_OK;
          acc_nxt    = '0;
          start_nxt  = '0;
          iss_nxt    = '0;
          end_nxt    = count_r;
          state_nxt  = S_WALK;
          case (q_cmd.kind)
            KIND_IMM: begin
              status_nxt = q_cmd.status;
              state_nxt  = S_FINISH;
            end
            KIND_APPEND: begin
              wr_en     = 1'b1;
              kind_nxt  = KIND_LIST;
              count_nxt = count_r + 1'b1;
              end_nxt   = count_r + 1'b1;
            end
            KIND_DELETE, KIND_MIN: begin
              start_nxt = {1'b0, q_cmd.pos};
              iss_nxt   = {1'b0, q_cmd.pos};
            end
            default: begin
              start_nxt = '0;
            end
          endcase
        end
      end
      S_WALK: begin
        if (consume) begin
          case (kind_r)
            KIND_LIST: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_value_nxt  = rd_ext;
              out_last_nxt   = rd_last;
            end
            KIND_MIN: begin
              if (rd_first || (rd_ext < acc_r)) begin
                acc_nxt = rd_ext;
              end
            end
            KIND_SUM: begin
              acc_nxt = acc_r + rd_ext;
            end
            KIND_DELETE: begin
              if (rd_first) begin
                acc_nxt = rd_ext;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(rd_idx_r - 1'b1);
                wr_data = rd_data_r;
              end
              if (rd_last) begin
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
              acc_nxt = acc_r;
            end
          endcase
          if (rd_last) begin
            state_nxt = (kind_r == KIND_LIST) ? S_IDLE : S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = acc_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[iss_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    status_r     <= status_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    iss_r        <= iss_nxt;
    rd_idx_r     <= rd_idx_nxt;
    acc_r        <= acc_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;

  `ILMS_ASSERT(a_count_cap, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY), "count over capacity")
  `ILMS_ASSERT(a_rd_in_walk, clk, rst_n, rd_valid_r, state_r == S_WALK, "read data outside walk")
  `ILMS_ASSERT(a_walk_bounds, clk, rst_n, state_r == S_WALK, (iss_r <= end_r) && (end_r == count_r), "walk index out of bounds")
  `ILMS_ASSERT_NEXT(a_finish_out, clk, rst_n, (state_r == S_FINISH) && out_free, out_valid_r && out_last_r && (state_r == S_IDLE), "final result not loaded")

endmodule

/* hw/rtl/indexed_list_with_min_sum.sv */
// ----------------------------------------------------------------------------
// indexed_list_with_min_sum
// ordered list of signed 32-bit values with print, append, delete,
// min-from-index and exact sum requests
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with in_op, in_item_value, in_position;
// a request is taken when in_valid is high and in_stall is low
// result channel: out_valid / out_stall with out_status, out_result_value,
// out_last; out_last marks the final result of each request
// the front classifies a request in the cycle it is taken and queues it
// (four deep); in_stall rises only when that queue is full
// the list engine serves one request at a time from a one-read one-write
// memory, walking one entry per cycle except while out_stall holds a
// print or append walk; a list result passes the queue, a registered
// memory read and the result register, a status-only result skips the read
// out_stall holds the result register; a print or append walk pauses behind
// it, other walks run on and wait to load their final result, and requests
// keep queuing until the queue fills
// reset (rst_n low, synchronous) empties the list and the queue; memory
// contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module indexed_list_with_min_sum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ilms_pkg::OP_W-1:0]         in_op,
  input  logic signed [ilms_pkg::VAL_W-1:0] in_item_value,
  input  logic [ilms_pkg::POS_W-1:0]        in_position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ilms_pkg::ST_W-1:0]         out_status,
  output logic signed [ilms_pkg::RES_W-1:0] out_result_value,
  output logic                              out_last
);
  import ilms_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  ilms_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_item_value (in_item_value),
    .in_position   (in_position),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  ilms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  ilms_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_last         (out_last)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: indexed_list_with_min_sum testbench
// drives print, append, delete, min-from-index and sum requests, plus the
// unused op codes, against a list model kept inside the bench; every result
// is checked in order against that model while both sides idle at random,
// with one long receiver hold-off that backs up the request queue
// ----------------------------------------------------------------------------
module tb_top;
  import ilms_pkg::*;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [RES_W-1:0] value;
    logic                    last;
  } list_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op;
  logic signed [VAL_W-1:0] in_item_value;
  logic [POS_W-1:0]        in_position;
  logic                    out_valid;
  logic                    out_stall;
  logic [ST_W-1:0]         out_status;
  logic signed [RES_W-1:0] out_result_value;
  logic                    out_last;

  logic signed [VAL_W-1:0] model_entries [CAPACITY];
  int                      model_count;
  list_result_t            pending_results [$];
  int                      mismatch_count;
  int                      hold_request;
  bit                      send_gapless;
  bit                      take_gapless;

  indexed_list_with_min_sum dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_item_value    (in_item_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void push_result(logic [ST_W-1:0] status, logic signed [RES_W-1:0] value,
                                      logic last);
    list_result_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  function automatic void push_list_dump();
    if (model_count == 0) begin
      push_result(ST_EMPTY, '0, 1'b1);
    end else begin
      for (int i = 0; i < model_count; i++)
        push_result(ST_OK, model_entries[i], i + 1 == model_count);
    end
  endfunction

  // list model: updates the entries and queues the results of one request
  function automatic void apply_list_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                                             logic [POS_W-1:0] pos);
    logic signed [VAL_W-1:0] low;
    longint                  total;
    case (op)
      OP_PRINT: begin
        push_list_dump();
      end
      OP_APPEND: begin
        if (model_count >= CAPACITY) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          model_entries[model_count] = val;
          model_count++;
          push_list_dump();
        end
      end
      OP_DELETE, OP_MIN: begin
        if (model_count == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else if (int'(pos) >= model_count) begin
          push_result(ST_RANGE, '0, 1'b1);
        end else if (op == OP_DELETE) begin
          push_result(ST_OK, model_entries[pos], 1'b1);
          for (int i = pos; i + 1 < model_count; i++)
            model_entries[i] = model_entries[i + 1];
          model_count--;
        end else begin
          low = model_entries[pos];
          for (int i = pos + 1; i < model_count; i++)
            if (model_entries[i] < low)
              low = model_entries[i];
          push_result(ST_OK, low, 1'b1);
        end
      end
      OP_SUM: begin
        total = 0;
        for (int i = 0; i < model_count; i++)
          total += model_entries[i];
        push_result(ST_OK, total[RES_W-1:0], 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                              logic [POS_W-1:0] pos);
    int gap;
    gap = send_gapless ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_item_value <= val;
    in_position   <= pos;
    do @(posedge clk); while (in_stall);
    apply_list_request(op, val, pos);
  endtask

  task automatic random_request();
    int                      pick;
    int                      append_limit;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    pick = $urandom_range(0, 99);
    append_limit = (model_count < 48) ? 48 : 30;
    if (pick < 3)
      op = OP_SUM + OP_W'($urandom_range(1, 3));
    else if (pick < append_limit)
      op = OP_APPEND;
    else if (pick < append_limit + 22)
      op = OP_DELETE;
    else if (pick < append_limit + 37)
      op = OP_MIN;
    else if (pick < append_limit + 45)
      op = OP_SUM;
    else
      op = OP_PRINT;
    case ($urandom_range(0, 7))
      0: val = 32'sh8000_0000;
      1: val = 32'sh7fff_ffff;
      default: val = $urandom;
    endcase
    if (model_count > 0 && $urandom_range(0, 9) < 8)
      pos = POS_W'($urandom_range(0, model_count - 1));
    else
      pos = POS_W'($urandom_range(0, 255));
    send_request(op, val, pos);
  endtask

  task automatic test_empty_list();
    send_request(OP_PRINT, 0, 0);
    send_request(OP_DELETE, 0, 0);
    send_request(OP_MIN, 0, 0);
    send_request(OP_SUM, 0, 0);
    for (int k = 1; k <= 3; k++)
      send_request(OP_SUM + OP_W'(k), 32'sh7fff_ffff, 8'hff);
  endtask

  task automatic test_basic_requests();
    send_request(OP_APPEND, 32'sh7fff_ffff, 0);
    send_request(OP_APPEND, 32'sh8000_0000, 8'hff);
    send_request(OP_APPEND, 0, 0);
    send_request(OP_APPEND, -1, 0);
    send_request(OP_APPEND, 5, 0);
    send_request(OP_PRINT, 0, 0);
    send_request(OP_SUM, 0, 0);
    send_request(OP_MIN, 0, 0);
    send_request(OP_MIN, 0, 4);
    send_request(OP_MIN, 0, 5);
    send_request(OP_MIN, 0, 8'hff);
    send_request(OP_DELETE, 0, 5);
    send_request(OP_DELETE, 0, 8'hff);
    send_request(OP_DELETE, 0, 2);
    send_request(OP_DELETE, 0, 3);
    send_request(OP_DELETE, 0, 0);
    send_request(OP_SUM, 0, 0);
    send_request(OP_PRINT, 0, 0);
  endtask

  // fill with mostly the most negative value so the sum nears its low end
  task automatic test_full_list();
    while (model_count < CAPACITY)
      send_request(OP_APPEND, ($urandom_range(0, 3) == 0) ? $urandom : 32'sh8000_0000, 0);
    send_request(OP_APPEND, 1, 0);
    send_request(OP_SUM, 0, 0);
    send_request(OP_PRINT, 0, 0);
    send_request(OP_MIN, 0, 8'(CAPACITY - 1));
    send_request(OP_DELETE, 0, 8'(CAPACITY - 1));
    send_request(OP_DELETE, 0, 0);
  endtask

  task automatic test_result_backpressure();
    hold_request = 400;
    send_request(OP_PRINT, 0, 0);
    send_gapless = 1'b1;
    repeat (20) random_request();
    send_gapless = 1'b0;
  endtask

  task automatic test_random_mix();
    repeat (160) random_request();
  endtask

  task automatic test_gapless_stretch();
    send_gapless = 1'b1;
    take_gapless = 1'b1;
    repeat (40) random_request();
    send_gapless = 1'b0;
    take_gapless = 1'b0;
  endtask

  // result side stall pattern
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end else begin
        hold = take_gapless ? 0 : $urandom_range(0, 12);
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d value %0d last %0b",
                   out_status, out_result_value, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_result_value !== want.value ||
            out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d value %0d last %0b, got %0d %0d %0b",
                     want.status, want.value, want.last,
                     out_status, out_result_value, out_last);
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_PRINT;
    in_item_value  = '0;
    in_position    = '0;
    model_count    = 0;
    mismatch_count = 0;
    hold_request   = 0;
    send_gapless   = 1'b0;
    take_gapless   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_basic_requests();
    test_full_list();
    test_result_backpressure();
    test_random_mix();
    test_gapless_stretch();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
